@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/evkdf_pkg.sv @@
package evkdf_pkg;

  localparam int unsigned ActW   = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned RoomW  = 32;
  localparam int unsigned IdW    = 64;
  localparam int unsigned StsW   = 3;
  localparam int unsigned CountW = 7;

  localparam logic [ActW-1:0] ACT_RECORD = 2'd0;
  localparam logic [ActW-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ActW-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [KindW-1:0] KIND_TWO_PARTY = 2'd0;
  localparam logic [KindW-1:0] KIND_DEATH     = 2'd1;
  localparam logic [KindW-1:0] KIND_RESOLVE   = 2'd2;

  localparam logic [StsW-1:0] STS_FIRST   = 3'd0;
  localparam logic [StsW-1:0] STS_DUP     = 3'd1;
  localparam logic [StsW-1:0] STS_INVALID = 3'd2;
  localparam logic [StsW-1:0] STS_FULL    = 3'd3;
  localparam logic [StsW-1:0] STS_DONE    = 3'd4;

  // command held at the top and seen by every cell
  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [KindW-1:0] kind;
    logic [RoomW-1:0] room;
    logic [IdW-1:0]   prim;
    logic [IdW-1:0]   sec;
    logic             ok;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic matched;
    logic inserted;
  } tok_t;

endpackage

@@ hw/rtl/evkdf_cell.sv @@
module evkdf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  evkdf_pkg::cmd_t    cmd_i,
  input  evkdf_pkg::tok_t    tok_i,
  output evkdf_pkg::tok_t    tok_o
);

  logic                         valid_q, valid_d;
  logic [evkdf_pkg::KindW-1:0]  kind_q;
  logic [evkdf_pkg::RoomW-1:0]  room_q;
  logic [evkdf_pkg::IdW-1:0]    prim_q;
  logic [evkdf_pkg::IdW-1:0]    sec_q;
  evkdf_pkg::tok_t              tok_q, tok_d;
  logic                         hit;
  logic                         take;

  assign hit = valid_q && (kind_q == cmd_i.kind) && (room_q == cmd_i.room) &&
               (prim_q == cmd_i.prim) && (sec_q == cmd_i.sec);

  // entries stay packed from slot 0, so every stored key lies ahead of the
  // first free cell and the match flag is final when the token gets here
  assign take = tok_i.valid && (cmd_i.act == evkdf_pkg::ACT_RECORD) && cmd_i.ok &&
                !tok_i.matched && !tok_i.inserted && !valid_q;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.valid) begin
      if (cmd_i.act == evkdf_pkg::ACT_CLEAR) begin
        valid_d = 1'b0;
      end else if (cmd_i.act == evkdf_pkg::ACT_RECORD ||
                   cmd_i.act == evkdf_pkg::ACT_LOOKUP) begin
        tok_d.matched = tok_i.matched | hit;
        if (take) begin
          valid_d        = 1'b1;
          tok_d.inserted = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && take) begin
      kind_q <= cmd_i.kind;
      room_q <= cmd_i.room;
      prim_q <= cmd_i.prim;
      sec_q  <= cmd_i.sec;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hw/rtl/event_key_duplicate_filter.sv @@
// Exact-match duplicate filter over a table of CAPACITY event keys, one key per cell
// in a row of cells. An accepted word launches a token that walks the row one cell per
// cycle while the row is not held: it compares against each stored key, takes the first
// free cell for a new valid key, or empties each cell for a clear. From the last cell the
// result is loaded into the output register, and only then is the next word accepted, so
// no word is taken in while another walks the row; the row is held while a finished token
// meets a stalled output word. A finished result may wait in the output register while
// the next word is already taken in. A full table reports table full for a new key but
// still reports duplicates; stored_count carries the low seven bits of the key count.
module event_key_duplicate_filter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [evkdf_pkg::ActW-1:0]        action_i,
  input  logic [evkdf_pkg::KindW-1:0]       event_kind_i,
  input  logic [evkdf_pkg::RoomW-1:0]       room_id_i,
  input  logic [evkdf_pkg::IdW-1:0]         primary_id_i,
  input  logic [evkdf_pkg::IdW-1:0]         secondary_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [evkdf_pkg::StsW-1:0]        status_o,
  output logic                              found_o,
  output logic [evkdf_pkg::CountW-1:0]      stored_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  evkdf_pkg::cmd_t                 cmd_q;
  logic                            key_ok;
  logic                            busy_q;
  logic                            start_q;
  logic                            adv;
  logic                            accept;
  logic                            res_load;
  logic [CntW-1:0]                 count_q;
  logic                            out_valid_q;
  logic [evkdf_pkg::StsW-1:0]      status_q, status_d;
  logic                            found_q, found_d;
  evkdf_pkg::tok_t                 tok [CAPACITY+1];
  evkdf_pkg::tok_t                 tok_end;

  always_comb begin
    key_ok = 1'b0;
    if (room_id_i != '0 && primary_id_i != '0) begin
      if (event_kind_i == evkdf_pkg::KIND_TWO_PARTY) begin
        key_ok = (secondary_id_i != '0) && (secondary_id_i != primary_id_i);
      end else if (event_kind_i inside {evkdf_pkg::KIND_DEATH, evkdf_pkg::KIND_RESOLVE}) begin
        key_ok = (secondary_id_i == '0);
      end
    end
  end

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign tok_end    = tok[CAPACITY];
  // the row holds only while a finished token cannot leave
  assign adv        = !(tok_end.valid && out_valid_q && out_stall_i);
  assign res_load   = tok_end.valid && adv;

  assign tok[0] = '{valid: start_q, matched: 1'b0, inserted: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    evkdf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cmd_i  (cmd_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_comb begin
    status_d = evkdf_pkg::STS_DONE;
    found_d  = 1'b0;
    case (cmd_q.act)
      evkdf_pkg::ACT_RECORD: begin
        if (!cmd_q.ok) begin
          status_d = evkdf_pkg::STS_INVALID;
        end else if (tok_end.matched) begin
          status_d = evkdf_pkg::STS_DUP;
        end else if (tok_end.inserted) begin
          status_d = evkdf_pkg::STS_FIRST;
        end else begin
          status_d = evkdf_pkg::STS_FULL;
        end
      end
      evkdf_pkg::ACT_LOOKUP: begin
        found_d = tok_end.matched;
      end
      default: begin
        status_d = evkdf_pkg::STS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= '{act: action_i, kind: event_kind_i, room: room_id_i,
                 prim: primary_id_i, sec: secondary_id_i, ok: key_ok};
    end
    if (res_load) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q  <= 1'b1;
        start_q <= 1'b1;
      end else begin
        if (adv) begin
          start_q <= 1'b0;
        end
        if (res_load) begin
          busy_q <= 1'b0;
        end
      end
      if (res_load) begin
        if (cmd_q.act == evkdf_pkg::ACT_CLEAR) begin
          count_q <= '0;
        end else if (tok_end.inserted) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // count held in the output word is the one after this word
  logic [CntW-1:0] count_out_q;
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (cmd_q.act == evkdf_pkg::ACT_CLEAR) begin
        count_out_q <= '0;
      end else if (tok_end.inserted) begin
        count_out_q <= count_q + 1'b1;
      end else begin
        count_out_q <= count_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign stored_count_o = evkdf_pkg::CountW'(count_out_q);

endmodule

@@ hw/rtl/evkdf_checker.sv @@
`include "assert_macros.svh"

module evkdf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [evkdf_pkg::ActW-1:0]        action_i,
  input logic [evkdf_pkg::KindW-1:0]       event_kind_i,
  input logic [evkdf_pkg::RoomW-1:0]       room_id_i,
  input logic [evkdf_pkg::IdW-1:0]         primary_id_i,
  input logic [evkdf_pkg::IdW-1:0]         secondary_id_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [evkdf_pkg::StsW-1:0]        status_o,
  input logic                              found_o,
  input logic [evkdf_pkg::CountW-1:0]      stored_count_o
);

  // a stalled result word stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(found_o) && $stable(stored_count_o))

  // one word in flight: taking a word closes the input
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // found only comes with a finished lookup
  `ASSERT_IMPLIES(a_found_done, clk_i, rst_ni, out_valid_o && found_o, status_o == evkdf_pkg::STS_DONE)

  // a first acceptance always leaves at least one key stored
  `ASSERT_IMPLIES(a_first_count, clk_i, rst_ni, out_valid_o && status_o == evkdf_pkg::STS_FIRST, stored_count_o != '0)

endmodule

bind event_key_duplicate_filter evkdf_checker u_evkdf_checker (.*);

@@ bench/event_key_duplicate_filter_tb.sv @@
module event_key_duplicate_filter_tb;

  localparam int unsigned TABLE_SIZE  = 64;
  localparam int unsigned POOL_SIZE   = 80;
  localparam int unsigned PHASE_WORDS = 460;
  localparam int unsigned HOLD_CYCLES = 900;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // action and kind codes the block must treat as unknown
  localparam logic [evkdf_pkg::ActW-1:0]  ACT_NONE     = 2'd3;
  localparam logic [evkdf_pkg::KindW-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [evkdf_pkg::KindW-1:0] kind;
    logic [evkdf_pkg::RoomW-1:0] room;
    logic [evkdf_pkg::IdW-1:0]   prim;
    logic [evkdf_pkg::IdW-1:0]   sec;
  } event_key_t;

  typedef struct packed {
    logic [evkdf_pkg::StsW-1:0]   status;
    logic                         found;
    logic [evkdf_pkg::CountW-1:0] count;
  } verdict_t;

  class key_table_scoreboard;
    bit          slot_used [TABLE_SIZE];
    event_key_t  slot_key [TABLE_SIZE];
    int unsigned key_total;
    verdict_t    pending_verdicts [$];
    int unsigned mismatches;

    function bit holds_key(event_key_t k);
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] == k) return 1'b1;
      return 1'b0;
    endfunction

    // predicts the verdict for an accepted word and updates the shadow table
    function void note_word(logic [evkdf_pkg::ActW-1:0] act, event_key_t k);
      verdict_t v;
      bit       well_formed;
      int       slot;
      v.status = evkdf_pkg::STS_DONE;
      v.found = 1'b0;
      well_formed = (k.room != '0) && (k.prim != '0);
      case (k.kind)
        evkdf_pkg::KIND_TWO_PARTY: well_formed &= (k.sec != '0) && (k.sec != k.prim);
        evkdf_pkg::KIND_DEATH, evkdf_pkg::KIND_RESOLVE: well_formed &= (k.sec == '0);
        default: well_formed = 1'b0;
      endcase
      case (act)
        evkdf_pkg::ACT_RECORD: begin
          if (!well_formed) v.status = evkdf_pkg::STS_INVALID;
          else if (holds_key(k)) v.status = evkdf_pkg::STS_DUP;
          else if (key_total >= TABLE_SIZE) v.status = evkdf_pkg::STS_FULL;
          else begin
            slot = 0;
            while (slot_used[slot]) slot++;
            slot_used[slot] = 1'b1;
            slot_key[slot] = k;
            key_total++;
            v.status = evkdf_pkg::STS_FIRST;
          end
        end
        evkdf_pkg::ACT_LOOKUP: v.found = holds_key(k);
        evkdf_pkg::ACT_CLEAR: begin
          slot_used = '{default: 1'b0};
          key_total = 0;
        end
        default: ;
      endcase
      v.count = key_total[evkdf_pkg::CountW-1:0];
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic [evkdf_pkg::StsW-1:0] sts, logic fnd,
                               logic [evkdf_pkg::CountW-1:0] cnt);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d found %0d count %0d", sts, fnd, cnt);
        return;
      end
      v = pending_verdicts.pop_front();
      if (sts !== v.status || fnd !== v.found || cnt !== v.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d found %0d count %0d, got %0d %0d %0d",
                   v.status, v.found, v.count, sts, fnd, cnt);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [evkdf_pkg::ActW-1:0]   action_i;
  logic [evkdf_pkg::KindW-1:0]  event_kind_i;
  logic [evkdf_pkg::RoomW-1:0]  room_id_i;
  logic [evkdf_pkg::IdW-1:0]    primary_id_i;
  logic [evkdf_pkg::IdW-1:0]    secondary_id_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [evkdf_pkg::StsW-1:0]   status_o;
  logic                         found_o;
  logic [evkdf_pkg::CountW-1:0] stored_count_o;

  key_table_scoreboard sb;
  event_key_t          key_pool [POOL_SIZE];
  int unsigned         idle_pct = 0;
  int unsigned         stall_pct = 0;
  logic                hold_on = 1'b0;
  int unsigned         cycle_count = 0;

  event_key_duplicate_filter #(
    .CAPACITY(TABLE_SIZE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .event_kind_i  (event_kind_i),
    .room_id_i     (room_id_i),
    .primary_id_i  (primary_id_i),
    .secondary_id_i(secondary_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .stored_count_o(stored_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("event_key_duplicate_filter regression: fail");
      $finish;
    end
  end

  // result side: take the word seen at this edge, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(status_o, found_o, stored_count_o);
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  task automatic send_word(input logic [evkdf_pkg::ActW-1:0] act, input event_key_t k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    event_kind_i   <= k.kind;
    room_id_i      <= k.room;
    primary_id_i   <= k.prim;
    secondary_id_i <= k.sec;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(act, k);
  endtask

  function automatic event_key_t fresh_key();
    event_key_t k;
    k.kind = evkdf_pkg::KindW'($urandom_range(2));
    k.room = $urandom;
    if (k.room == '0) k.room = 32'd1;
    k.prim = {$urandom, $urandom};
    if (k.prim == '0) k.prim = 64'd1;
    k.sec = '0;
    if (k.kind == evkdf_pkg::KIND_TWO_PARTY)
      do k.sec = {$urandom, $urandom}; while (k.sec == '0 || k.sec == k.prim);
    return k;
  endfunction

  function automatic event_key_t broken_key(event_key_t k);
    case ($urandom_range(3))
      0: k.room = '0;
      1: k.prim = '0;
      2: k.kind = KIND_UNKNOWN;
      default: begin
        if (k.kind == evkdf_pkg::KIND_TWO_PARTY) k.sec = $urandom_range(1) ? '0 : k.prim;
        else k.sec = {$urandom, $urandom} | 64'd1;
      end
    endcase
    return k;
  endfunction

  // pool of valid keys; some are near neighbours of the previous one
  task automatic build_pool();
    event_key_t k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        k = key_pool[i-1];
        case ($urandom_range(2))
          0: k.room = k.room ^ (32'd1 << $urandom_range(31));
          1: k.prim = k.prim ^ (64'd1 << $urandom_range(63));
          default: begin
            if (k.kind == evkdf_pkg::KIND_DEATH) k.kind = evkdf_pkg::KIND_RESOLVE;
            else if (k.kind == evkdf_pkg::KIND_RESOLVE) k.kind = evkdf_pkg::KIND_DEATH;
            else k.sec = k.sec ^ (64'd1 << $urandom_range(63));
          end
        endcase
        if (k.room == '0 || k.prim == '0 ||
            (k.kind == evkdf_pkg::KIND_TWO_PARTY && (k.sec == '0 || k.sec == k.prim)))
          k = fresh_key();
      end else begin
        k = fresh_key();
      end
      key_pool[i] = k;
    end
  endtask

  task automatic random_word();
    event_key_t  k;
    int unsigned pick;
    k = key_pool[$urandom_range(POOL_SIZE-1)];
    pick = $urandom_range(999);
    if (pick < 560) send_word(evkdf_pkg::ACT_RECORD, k);
    else if (pick < 790) send_word(evkdf_pkg::ACT_LOOKUP, k);
    else if (pick < 870) send_word(evkdf_pkg::ACT_RECORD, broken_key(k));
    else if (pick < 930)
      send_word(evkdf_pkg::ACT_LOOKUP, $urandom_range(1) ? broken_key(k) : fresh_key());
    else if (pick < 960) send_word(ACT_NONE, broken_key(fresh_key()));
    else if (pick < 964) send_word(evkdf_pkg::ACT_CLEAR, k);
    else send_word(evkdf_pkg::ACT_RECORD, fresh_key());
  endtask

  initial begin
    event_key_t  hi_key;
    event_key_t  death_key;
    event_key_t  resolve_key;
    event_key_t  k;
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    phase_idle  = '{0, 72, 0, 14};
    phase_stall = '{0, 0, 72, 14};
    sb = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = '0;
    event_kind_i   = '0;
    room_id_i      = '0;
    primary_id_i   = '0;
    secondary_id_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    hi_key      = '{evkdf_pkg::KIND_TWO_PARTY, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1};
    death_key   = '{evkdf_pkg::KIND_DEATH, 32'd1, 64'd1, 64'd0};
    resolve_key = '{evkdf_pkg::KIND_RESOLVE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
    send_word(evkdf_pkg::ACT_RECORD, hi_key);
    send_word(evkdf_pkg::ACT_RECORD, hi_key);
    send_word(evkdf_pkg::ACT_LOOKUP, hi_key);
    send_word(evkdf_pkg::ACT_RECORD, death_key);
    send_word(evkdf_pkg::ACT_RECORD, resolve_key);
    // same ids under another kind must not match
    k = resolve_key;
    k.kind = evkdf_pkg::KIND_DEATH;
    send_word(evkdf_pkg::ACT_LOOKUP, k);
    k = hi_key;
    k.room = '0;
    send_word(evkdf_pkg::ACT_RECORD, k);
    send_word(evkdf_pkg::ACT_LOOKUP, k);
    k = death_key;
    k.prim = '0;
    send_word(evkdf_pkg::ACT_RECORD, k);
    k = death_key;
    k.kind = KIND_UNKNOWN;
    send_word(evkdf_pkg::ACT_RECORD, k);
    k = hi_key;
    k.sec = '0;
    send_word(evkdf_pkg::ACT_RECORD, k);
    k.sec = k.prim;
    send_word(evkdf_pkg::ACT_RECORD, k);
    k = death_key;
    k.sec = 64'hFFFF_FFFF_FFFF_FFFF;
    send_word(evkdf_pkg::ACT_RECORD, k);
    send_word(ACT_NONE, hi_key);
    send_word(evkdf_pkg::ACT_CLEAR, hi_key);
    send_word(evkdf_pkg::ACT_LOOKUP, hi_key);
    send_word(evkdf_pkg::ACT_RECORD, hi_key);
    send_word(evkdf_pkg::ACT_RECORD,
              '{evkdf_pkg::KIND_TWO_PARTY, 32'd1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF});
    send_word(ACT_NONE, broken_key(fresh_key()));

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = phase_idle[phase];
      stall_pct = phase_stall[phase];
      build_pool();
      send_word(evkdf_pkg::ACT_CLEAR, key_pool[0]);
      // long receiver hold-off while words keep coming, so the input backs up
      if (phase == 0)
        fork
          begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_on <= 1'b0;
          end
        join_none
      repeat (PHASE_WORDS) random_word();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (2 * TABLE_SIZE + 8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("event_key_duplicate_filter regression: pass");
    else
      $display("event_key_duplicate_filter regression: fail");
    $finish;
  end

endmodule
